>>> rtl/bitmask_sparse_byte_expander_unit_assert.svh
// Assertion macros used by the checker module.
`ifndef BITMASK_SPARSE_BYTE_EXPANDER_UNIT_ASSERT_SVH
`define BITMASK_SPARSE_BYTE_EXPANDER_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define BSBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsbe assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define BSBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsbe assertion failed");

`endif

>>> rtl/bsbe_pkg.sv
package bsbe_pkg;

    localparam int ROW_BYTES      = 64;
    localparam int BLOCK_ROWS_MAX = 64;
    localparam int WORD_SLOTS     = 8;
    localparam int WORD_W         = 64;
    localparam int MASK_W         = 64;
    localparam int BYTE_W         = 8;
    localparam int WIDX_W         = 3;
    localparam int RPB_W          = 7;
    localparam int ROWCNT_W       = 6;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam int WORD_COUNT = ((ROW_BYTES + 7) / 8 > WORD_SLOTS) ? WORD_SLOTS
                              : (ROW_BYTES + 7) / 8;
    localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(WORD_COUNT - 1);

    // Mask bits at or above the row length are ignored.
    localparam logic [MASK_W-1:0] ROW_BITS = (ROW_BYTES >= MASK_W) ? {MASK_W{1'b1}}
                                           : ((MASK_W'(1) << ROW_BYTES) - MASK_W'(1));

    localparam logic [RPB_W-1:0] RPB_RESET = RPB_W'(BLOCK_ROWS_MAX);
    localparam logic [RPB_W-1:0] RPB_MAX   = RPB_W'(BLOCK_ROWS_MAX);

    // Register index 0 at byte address 0; bit 2 selects the register slot.
    localparam logic REG_ROWS_PER_BLOCK = 1'b0;

    localparam logic OP_MASK = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef logic [WORD_SLOTS-1:0][WORD_W-1:0] t_row;

    typedef struct packed {
        t_row row;
        logic block_end;
    } t_emit;

endpackage

>>> rtl/bsbe_emit.sv
module bsbe_emit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  bsbe_pkg::t_emit           i_req,
    output logic                      o_busy,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [bsbe_pkg::WIDX_W-1:0] o_word_index,
    output logic [bsbe_pkg::WORD_W-1:0] o_row_word,
    output logic                      o_last_of_row,
    output logic                      o_last_of_block
);
    import bsbe_pkg::*;

    logic              r_busy;
    logic [WIDX_W-1:0] r_widx;
    t_row              r_row;
    logic              r_block_end;
    logic              take;
    logic              last_word;

    assign take      = r_busy && !i_out_stall;
    assign last_word = (r_widx == LAST_WIDX);

    // Advance the word pointer on each taken item; free the buffer after the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_widx <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_widx <= '0;
        end else if (take) begin
            if (last_word) begin
                r_busy <= 1'b0;
            end else begin
                r_widx <= r_widx + WIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row       <= i_req.row;
            r_block_end <= i_req.block_end;
        end
    end

    assign o_busy          = r_busy;
    assign o_out_valid     = r_busy;
    assign o_word_index    = r_widx;
    assign o_row_word      = r_row[r_widx];
    assign o_last_of_row   = last_word;
    assign o_last_of_block = last_word && r_block_end;

endmodule

>>> rtl/bitmask_sparse_byte_expander_unit.sv
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  input    | i_in_valid / o_in_stall    | i_operation, i_row_mask, i_data_byte
//  output   | o_out_valid / i_out_stall  | o_word_index, o_row_word, o_last_of_row,
//           |                            | o_last_of_block
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (rows_per_block)
//
//  One input item is taken per cycle while o_in_stall is low; the lowest-set-bit
//  pick on the pending mask and the byte write into the row store settle within that cycle.
//  A completed row is handed to a one-row output buffer and leaves as eight words,
//  one per cycle while i_out_stall is low.
//  Items that do not complete a row are accepted while the buffer drains; an item
//  that completes a row is held until the buffer is free, which is the cycle after
//  its eighth word has been taken.
//  Reset is synchronous, active low; it clears the row state and sets
//  rows_per_block to 64. Output stall holds the buffer and, through it, any item
//  that completes a row.
module bitmask_sparse_byte_expander_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [bsbe_pkg::MASK_W-1:0]   i_row_mask,
    input  logic [bsbe_pkg::BYTE_W-1:0]   i_data_byte,
    // result item channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bsbe_pkg::WIDX_W-1:0]   o_word_index,
    output logic [bsbe_pkg::WORD_W-1:0]   o_row_word,
    output logic                          o_last_of_row,
    output logic                          o_last_of_block,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsbe_pkg::PADDR_W-1:0]  paddr,
    input  logic [bsbe_pkg::PDATA_W-1:0]  pwdata,
    output logic [bsbe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import bsbe_pkg::*;

    // Row build state. The row is open while any pending bit remains set.
    logic [MASK_W-1:0]                 r_pending;
    logic [WORD_SLOTS*8-1:0][BYTE_W-1:0] r_store;
    logic [ROWCNT_W-1:0]               r_row_cnt;
    logic [RPB_W-1:0]                  r_rows_per_block;

    logic [MASK_W-1:0]                 masked;
    logic [MASK_W-1:0]                 pick;
    logic [MASK_W-1:0]                 rest;
    logic [WORD_SLOTS*8-1:0][BYTE_W-1:0] filled;
    logic                              is_mask;
    logic                              row_open;
    logic                              completes;
    logic                              accept;
    logic                              emit;
    logic                              emit_busy;
    logic [RPB_W-1:0]                  limit;
    logic                              block_end;
    t_emit                             req;
    logic                              cfg_write;

    assign is_mask  = (i_operation == OP_MASK);
    assign masked   = i_row_mask & ROW_BITS;
    assign row_open = (r_pending != '0);

    // Isolate the lowest pending bit; that is where the next packed byte lands.
    assign pick = r_pending & (~r_pending + MASK_W'(1));
    assign rest = r_pending & ~pick;

    always_comb begin
        for (int j = 0; j < WORD_SLOTS * 8; j++) begin
            if (j < MASK_W && pick[j]) begin
                filled[j] = i_data_byte;
            end else begin
                filled[j] = r_store[j];
            end
        end
    end

    // An empty mask emits at once; a byte that fills the last pending bit emits too.
    assign completes = is_mask ? (masked == '0) : (row_open && (rest == '0));

    // Hold only the items that would need the output buffer while it is in use.
    assign o_in_stall = emit_busy && completes;
    assign accept     = i_in_valid && !o_in_stall;
    assign emit       = accept && completes;

    // Clamp the block length to 1..BLOCK_ROWS_MAX.
    always_comb begin
        if (r_rows_per_block == '0) begin
            limit = RPB_W'(1);
        end else if (r_rows_per_block > RPB_MAX) begin
            limit = RPB_MAX;
        end else begin
            limit = r_rows_per_block;
        end
    end
    assign block_end = ({1'b0, r_row_cnt} + RPB_W'(1)) >= limit;

    // An empty mask emits the all-zero row; otherwise emit the row with this byte merged.
    assign req.row       = is_mask ? t_row'('0) : t_row'(filled);
    assign req.block_end = block_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_row_cnt <= '0;
        end else begin
            if (accept) begin
                if (is_mask) begin
                    r_pending <= masked;
                end else if (row_open) begin
                    r_pending <= rest;
                end
            end
            if (emit) begin
                if (block_end) begin
                    r_row_cnt <= '0;
                end else begin
                    r_row_cnt <= r_row_cnt + ROWCNT_W'(1);
                end
            end
        end
    end

    // Row store: clear on reset and on every new mask, merge each byte accepted while the row is open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
        end else if (accept) begin
            if (is_mask) begin
                r_store <= '0;
            end else if (row_open) begin
                r_store <= filled;
            end
        end
    end

    // Configuration register.
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == REG_ROWS_PER_BLOCK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_per_block <= RPB_RESET;
        end else if (cfg_write) begin
            r_rows_per_block <= pwdata[RPB_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS_PER_BLOCK)
                  ? PDATA_W'(r_rows_per_block) : '0;

    bsbe_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (emit),
        .i_req           (req),
        .o_busy          (emit_busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_word_index    (o_word_index),
        .o_row_word      (o_row_word),
        .o_last_of_row   (o_last_of_row),
        .o_last_of_block (o_last_of_block)
    );

endmodule

>>> rtl/bsbe_checker.sv
`include "bitmask_sparse_byte_expander_unit_assert.svh"

module bsbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_word_index,
    input logic [63:0] o_row_word,
    input logic        o_last_of_row,
    input logic        o_last_of_block
);

    // A stalled result item stays offered and unchanged.
    `BSBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `BSBE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_row_word) && $stable(o_word_index))

    // Block end only on a row end, and the row end is the eighth word.
    `BSBE_ASSERT_NOW(a_block_in_row, i_clk, i_rst_n, o_out_valid && o_last_of_block, o_last_of_row)
    `BSBE_ASSERT_NOW(a_row_end_idx, i_clk, i_rst_n, o_out_valid, o_last_of_row == (o_word_index == 3'd7))

    // Words of a row follow each other without a gap.
    `BSBE_ASSERT_NEXT(a_word_step, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last_of_row, o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))

endmodule

bind bitmask_sparse_byte_expander_unit bsbe_checker u_bsbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_word_index    (o_word_index),
    .o_row_word      (o_row_word),
    .o_last_of_row   (o_last_of_row),
    .o_last_of_block (o_last_of_block)
);
